### rtl/polygon_area_centroid_energy_assert.svh
// Assertion macros shared by the checker.
`ifndef POLYGON_AREA_CENTROID_ENERGY_ASSERT_SVH
`define POLYGON_AREA_CENTROID_ENERGY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PCAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pcae_pkg.sv
package pcae_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;

  // Largest Q7.56 value
  localparam logic [62:0] QMAX = {63{1'b1}};

  // Divider lengths: energy quotient chunks, centroid numerator bits
  localparam int unsigned E_CHUNK     = 14;
  localparam logic [6:0]  DIV_E_ITERS = 7'd5;
  localparam logic [6:0]  DIV_C_ITERS = 7'd108;

  // Micro-operations; multiply steps also pass through S_ACC
  typedef enum logic [5:0] {
    U_EX1, U_EX2, U_CEX, U_CX1, U_CX2, U_CSX, U_CY1, U_CY2, U_CSY,
    U_TR1, U_TR2, U_CTR,
    U_E1, U_E2, U_E3, U_E4, U_E5, U_E6, U_E7, U_E8, U_E9, U_E10, U_E11, U_E12,
    U_CEL, U_MM1, U_MM2, U_MM3, U_MM4, U_DVE, U_CEN,
    U_FIRST, U_PREV, U_DVX, U_CX, U_DVY, U_CY, U_OUT
  } uop_t;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_ACC, S_DIV} state_t;

  typedef struct packed {
    uop_t uop;
    logic closing;
    logic cap_in;
    logic mul_en;
    logic acc_en;
    logic commit_en;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic degen;
  } status_t;

  function automatic logic is_mul(uop_t u);
    return u inside {U_EX1, U_EX2, U_CX1, U_CX2, U_CY1, U_CY2, U_TR1, U_TR2,
                     [U_E1:U_E12], [U_MM1:U_MM4]};
  endfunction

endpackage

### rtl/pcae_ctrl.sv
module pcae_ctrl #(
  parameter int unsigned MAX_VERTICES = pcae_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output pcae_pkg::cmd_t    cmd,
  input  pcae_pkg::status_t status
);

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  pcae_pkg::state_t state, state_next;
  pcae_pkg::uop_t   uop, uop_next, uop_after, adv_uop;
  pcae_pkg::state_t adv_state;
  logic             closing, closing_next, adv_closing;
  logic             last, last_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [6:0]       dcnt, dcnt_next;
  logic             out_valid_next;
  logic             accept, vertex_done, out_free, is_div;

  assign accept      = in_valid && (state == pcae_pkg::S_IDLE);
  assign out_free    = !out_valid || !out_stall;
  assign vertex_done = (uop == pcae_pkg::U_FIRST) || (uop == pcae_pkg::U_PREV);
  assign is_div      = (uop == pcae_pkg::U_DVE) || (uop == pcae_pkg::U_DVX) ||
                       (uop == pcae_pkg::U_DVY);

  // Pick the step that follows the current one
  always_comb begin
    case (uop)
      pcae_pkg::U_CSY: begin
        if (closing) begin
          uop_after = status.degen ? pcae_pkg::U_OUT : pcae_pkg::U_DVX;
        end else begin
          uop_after = (cnt >= CW'(2)) ? pcae_pkg::U_TR1 : pcae_pkg::U_PREV;
        end
      end
      pcae_pkg::U_CEN: uop_after = pcae_pkg::U_PREV;
      pcae_pkg::U_CY:  uop_after = pcae_pkg::U_OUT;
      default:         uop_after = pcae_pkg::uop_t'(uop + 6'd1);
    endcase
  end

  // Advance after a finished step; a finished vertex closes the polygon on last
  always_comb begin
    adv_closing = closing;
    adv_state   = pcae_pkg::S_EXEC;
    adv_uop     = uop_after;
    if (vertex_done) begin
      if (last) begin
        adv_uop     = pcae_pkg::U_EX1;
        adv_closing = 1'b1;
      end else begin
        adv_state = pcae_pkg::S_IDLE;
      end
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    uop_next     = uop;
    closing_next = closing;
    last_next    = last;
    cnt_next     = cnt;
    dcnt_next    = dcnt;
    case (state)
      pcae_pkg::S_IDLE: begin
        if (accept) begin
          last_next    = in_last;
          closing_next = 1'b0;
          if (cnt < CW'(MAX_VERTICES)) begin
            uop_next   = (cnt == '0) ? pcae_pkg::U_FIRST : pcae_pkg::U_EX1;
            state_next = pcae_pkg::S_EXEC;
          end else if (in_last) begin
            uop_next     = pcae_pkg::U_EX1;
            closing_next = 1'b1;
            state_next   = pcae_pkg::S_EXEC;
          end
        end
      end
      pcae_pkg::S_EXEC: begin
        if (uop == pcae_pkg::U_OUT) begin
          if (out_free) begin
            state_next = pcae_pkg::S_IDLE;
            cnt_next   = '0;
          end
        end else if (pcae_pkg::is_mul(uop)) begin
          state_next = pcae_pkg::S_ACC;
        end else if (is_div) begin
          state_next = pcae_pkg::S_DIV;
          dcnt_next  = (uop == pcae_pkg::U_DVE) ? pcae_pkg::DIV_E_ITERS
                                                : pcae_pkg::DIV_C_ITERS;
        end else begin
          state_next   = adv_state;
          uop_next     = adv_uop;
          closing_next = adv_closing;
          if (vertex_done) cnt_next = cnt + CW'(1);
        end
      end
      pcae_pkg::S_ACC: begin
        state_next   = adv_state;
        uop_next     = adv_uop;
        closing_next = adv_closing;
      end
      pcae_pkg::S_DIV: begin
        dcnt_next = dcnt - 7'd1;
        if (dcnt == 7'd1) begin
          uop_next   = pcae_pkg::uop_t'(uop + 6'd1);
          state_next = pcae_pkg::S_EXEC;
        end
      end
      default: state_next = pcae_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd.uop       = uop;
    cmd.closing   = closing;
    cmd.cap_in    = accept;
    cmd.mul_en    = (state == pcae_pkg::S_EXEC) && pcae_pkg::is_mul(uop);
    cmd.acc_en    = (state == pcae_pkg::S_ACC);
    cmd.commit_en = (state == pcae_pkg::S_EXEC) && !pcae_pkg::is_mul(uop) &&
                    (uop != pcae_pkg::U_OUT);
    cmd.div_step  = (state == pcae_pkg::S_DIV);
    cmd.out_load  = (state == pcae_pkg::S_EXEC) && (uop == pcae_pkg::U_OUT) && out_free;
    in_stall      = (state != pcae_pkg::S_IDLE);
  end

  // Hold a result beat until taken
  assign out_valid_next = cmd.out_load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcae_pkg::S_IDLE;
      uop       <= pcae_pkg::U_EX1;
      closing   <= 1'b0;
      last      <= 1'b0;
      cnt       <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      uop       <= uop_next;
      closing   <= closing_next;
      last      <= last_next;
      cnt       <= cnt_next;
      dcnt      <= dcnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/pcae_datapath.sv
module pcae_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pcae_pkg::cmd_t     cmd,
  output pcae_pkg::status_t  status,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] site_x,
  input  logic signed [31:0] site_y,
  output logic [62:0]        area_out,
  output logic signed [31:0] centroid_x,
  output logic signed [31:0] centroid_y,
  output logic [62:0]        energy_out,
  output logic               degenerate,
  output logic               saturated
);

  // Vertex registers
  logic signed [31:0] cur_x, cur_y, sin_x, sin_y;
  logic signed [31:0] first_x, first_y, prev_x, prev_y, site_px, site_py;

  // Sums
  logic [62:0] area_sum, energy_sum;
  logic [63:0] csum_x, csum_y;

  // Step temporaries
  logic signed [63:0]  crs;
  logic [65:0]         ct;
  logic [63:0]         el;
  logic signed [67:0]  prod;
  logic signed [129:0] acc;
  logic signed [31:0]  cx, cy;

  // Divider
  logic [107:0] num;
  logic [65:0]  den, rem;
  logic [69:0]  quo;
  logic         ovf, dneg;

  function automatic logic [62:0] sat_add(logic [62:0] s, logic [62:0] t);
    logic [63:0] sum;
    sum = {1'b0, s} + {1'b0, t};
    return sum[63] ? pcae_pkg::QMAX : sum[62:0];
  endfunction

  // Edge endpoints and corner offsets
  logic signed [31:0] ux, uy, vx, vy;
  logic signed [32:0] sx_e, sy_e, ax, ay, bx, by, px, py, qx, qy, rx, ry;
  logic [63:0]        c4;

  assign ux   = prev_x;
  assign uy   = prev_y;
  assign vx   = cmd.closing ? first_x : cur_x;
  assign vy   = cmd.closing ? first_y : cur_y;
  assign sx_e = 33'(ux) + 33'(vx);
  assign sy_e = 33'(uy) + 33'(vy);
  assign ax   = 33'(prev_x) - 33'(first_x);
  assign ay   = 33'(prev_y) - 33'(first_y);
  assign bx   = 33'(cur_x) - 33'(first_x);
  assign by   = 33'(cur_y) - 33'(first_y);
  assign px   = 33'(first_x) - 33'(site_px);
  assign py   = 33'(first_y) - 33'(site_py);
  assign qx   = 33'(prev_x) - 33'(site_px);
  assign qy   = 33'(prev_y) - 33'(site_py);
  assign rx   = 33'(cur_x) - 33'(site_px);
  assign ry   = 33'(cur_y) - 33'(site_py);
  assign c4   = 64'(ct >> 4);

  // Select multiplier operands, shift and accumulate mode
  logic signed [33:0] ma, mb;
  logic [6:0]         sh;
  logic               ld, sb;

  always_comb begin
    ma = '0;
    mb = '0;
    sh = 7'd0;
    ld = 1'b0;
    sb = 1'b0;
    case (cmd.uop)
      pcae_pkg::U_EX1: begin ma = 34'(ux); mb = 34'(vy); ld = 1'b1; end
      pcae_pkg::U_EX2: begin ma = 34'(uy); mb = 34'(vx); sb = 1'b1; end
      pcae_pkg::U_CX1: begin
        ma = 34'(sx_e); mb = 34'($signed(crs[63:32])); sh = 7'd32; ld = 1'b1;
      end
      pcae_pkg::U_CX2: begin ma = 34'(sx_e); mb = $signed({2'b00, crs[31:0]}); end
      pcae_pkg::U_CY1: begin
        ma = 34'(sy_e); mb = 34'($signed(crs[63:32])); sh = 7'd32; ld = 1'b1;
      end
      pcae_pkg::U_CY2: begin ma = 34'(sy_e); mb = $signed({2'b00, crs[31:0]}); end
      pcae_pkg::U_TR1: begin ma = 34'(ax); mb = 34'(by); ld = 1'b1; end
      pcae_pkg::U_TR2: begin ma = 34'(ay); mb = 34'(bx); sb = 1'b1; end
      pcae_pkg::U_E1:  begin ma = 34'(px); mb = 34'(px); ld = 1'b1; end
      pcae_pkg::U_E2:  begin ma = 34'(py); mb = 34'(py); end
      pcae_pkg::U_E3:  begin ma = 34'(px); mb = 34'(qx); end
      pcae_pkg::U_E4:  begin ma = 34'(py); mb = 34'(qy); end
      pcae_pkg::U_E5:  begin ma = 34'(px); mb = 34'(rx); end
      pcae_pkg::U_E6:  begin ma = 34'(py); mb = 34'(ry); end
      pcae_pkg::U_E7:  begin ma = 34'(qx); mb = 34'(qx); end
      pcae_pkg::U_E8:  begin ma = 34'(qy); mb = 34'(qy); end
      pcae_pkg::U_E9:  begin ma = 34'(qx); mb = 34'(rx); end
      pcae_pkg::U_E10: begin ma = 34'(qy); mb = 34'(ry); end
      pcae_pkg::U_E11: begin ma = 34'(rx); mb = 34'(rx); end
      pcae_pkg::U_E12: begin ma = 34'(ry); mb = 34'(ry); end
      pcae_pkg::U_MM1: begin
        ma = $signed({2'b00, el[31:0]});  mb = $signed({2'b00, c4[31:0]});  ld = 1'b1;
      end
      pcae_pkg::U_MM2: begin
        ma = $signed({2'b00, el[31:0]});  mb = $signed({2'b00, c4[63:32]}); sh = 7'd32;
      end
      pcae_pkg::U_MM3: begin
        ma = $signed({2'b00, el[63:32]}); mb = $signed({2'b00, c4[31:0]});  sh = 7'd32;
      end
      pcae_pkg::U_MM4: begin
        ma = $signed({2'b00, el[63:32]}); mb = $signed({2'b00, c4[63:32]}); sh = 7'd64;
      end
      default: begin end
    endcase
  end

  logic signed [129:0] pw;
  assign pw = 130'(prod) <<< sh;

  // Commit helpers
  logic [129:0] acc_neg;
  logic [65:0]  ct_mag;
  logic [63:0]  cs_sel, cs_mag;
  logic         cs_neg;
  logic [65:0]  den6;
  logic [62:0]  e_term;
  logic signed [31:0] cq;
  logic [66:0]  rs;
  logic         qbit;

  // Divide by three, one chunk of numerator bits per step
  logic [2:0]                    e_r3;
  logic [1:0]                    e_rem_next;
  logic [pcae_pkg::E_CHUNK-1:0]  e_q;

  assign acc_neg = -acc;
  assign ct_mag  = acc[129] ? acc_neg[65:0] : acc[65:0];
  assign cs_sel  = (cmd.uop == pcae_pkg::U_DVY) ? csum_y : csum_x;
  assign cs_neg  = cs_sel[63];
  assign cs_mag  = cs_neg ? (64'd0 - cs_sel) : cs_sel;
  assign den6    = ({3'b000, area_sum} << 2) + ({3'b000, area_sum} << 1);
  assign e_term  = (ovf || (quo > 70'(pcae_pkg::QMAX))) ? pcae_pkg::QMAX : quo[62:0];
  assign rs      = {rem, num[107]};
  assign qbit    = (rs >= {1'b0, den});

  // Run the remainder through a chunk of bits, compare and subtract three
  always_comb begin
    e_r3       = '0;
    e_rem_next = rem[1:0];
    e_q        = '0;
    for (int i = 0; i < int'(pcae_pkg::E_CHUNK); i++) begin
      e_r3 = {e_rem_next, num[107 - i]};
      if (e_r3 >= 3'd3) begin
        e_rem_next = 2'(e_r3 - 3'd3);
        e_q[pcae_pkg::E_CHUNK - 1 - i] = 1'b1;
      end else begin
        e_rem_next = e_r3[1:0];
      end
    end
  end

  // Saturate the centroid quotient to the signed 32-bit range
  always_comb begin
    if (!dneg) begin
      cq = (ovf || (quo > 70'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(quo[31:0]);
    end else begin
      cq = (ovf || (quo > 70'h80000000)) ? $signed(32'h80000000)
                                         : $signed(32'd0 - quo[31:0]);
    end
  end

  assign status.degen = (area_sum == '0);

  // Capture beats, multiply, accumulate
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cur_x <= vertex_x;
      cur_y <= vertex_y;
      sin_x <= site_x;
      sin_y <= site_y;
    end
    if (cmd.mul_en) prod <= ma * mb;
    if (cmd.acc_en) acc <= ld ? pw : (sb ? acc - pw : acc + pw);
  end

  // Commit steps, divider, result
  always_ff @(posedge clk) begin
    if (rst) begin
      area_sum   <= '0;
      energy_sum <= '0;
      csum_x     <= '0;
      csum_y     <= '0;
    end else begin
      if (cmd.commit_en) begin
        case (cmd.uop)
          pcae_pkg::U_CEX: crs <= acc[63:0];
          pcae_pkg::U_CSX: csum_x <= csum_x + acc[111:48];
          pcae_pkg::U_CSY: csum_y <= csum_y + acc[111:48];
          pcae_pkg::U_CTR: begin
            ct       <= ct_mag;
            area_sum <= sat_add(area_sum, 63'(ct_mag[65:5]));
          end
          pcae_pkg::U_CEL: el <= acc[67:4];
          // Divide by twelve: drop two more bits, then divide by three
          pcae_pkg::U_DVE: begin
            num  <= {acc[127:58], 38'd0};
            rem  <= '0;
            quo  <= '0;
            ovf  <= 1'b0;
            dneg <= 1'b0;
          end
          pcae_pkg::U_CEN: energy_sum <= sat_add(energy_sum, e_term);
          pcae_pkg::U_FIRST: begin
            first_x <= cur_x;
            first_y <= cur_y;
            prev_x  <= cur_x;
            prev_y  <= cur_y;
            site_px <= sin_x;
            site_py <= sin_y;
          end
          pcae_pkg::U_PREV: begin
            prev_x <= cur_x;
            prev_y <= cur_y;
          end
          pcae_pkg::U_DVX, pcae_pkg::U_DVY: begin
            num  <= {cs_mag, 44'd0};
            den  <= den6;
            rem  <= '0;
            quo  <= '0;
            ovf  <= 1'b0;
            dneg <= cs_neg;
          end
          pcae_pkg::U_CX: cx <= cq;
          pcae_pkg::U_CY: cy <= cq;
          default: begin end
        endcase
      end
      if (cmd.div_step) begin
        if (cmd.uop == pcae_pkg::U_DVE) begin
          // One chunk of the divide by three per cycle
          rem <= 66'(e_rem_next);
          quo <= (quo << pcae_pkg::E_CHUNK) | 70'(e_q);
          num <= num << pcae_pkg::E_CHUNK;
        end else begin
          // One restoring division bit per cycle
          rem <= qbit ? 66'(rs - {1'b0, den}) : rs[65:0];
          quo <= {quo[68:0], qbit};
          ovf <= ovf | quo[69];
          num <= {num[106:0], 1'b0};
        end
      end
      // Drop the sums once the result is loaded
      if (cmd.out_load) begin
        area_out   <= area_sum;
        energy_out <= energy_sum;
        centroid_x <= status.degen ? 32'sd0 : cx;
        centroid_y <= status.degen ? 32'sd0 : cy;
        degenerate <= status.degen;
        saturated  <= (area_sum == pcae_pkg::QMAX) || (energy_sum == pcae_pkg::QMAX);
        area_sum   <= '0;
        energy_sum <= '0;
        csum_x     <= '0;
        csum_y     <= '0;
      end
    end
  end

endmodule

### rtl/polygon_area_centroid_energy.sv
// Channel  Handshake                Payload
// input    in_valid / in_stall      vertex_x, vertex_y, site_x, site_y, last_vertex
// output   out_valid / out_stall    area_out, centroid_x, centroid_y, energy_out,
//                                   degenerate, saturated
//
// One vertex at a time through a single 34x34 multiplier. The first vertex is only
// stored; the second adds an edge to the centroid sums; later ones also add a fan
// triangle's area and energy, whose divide by twelve runs 14 bits a cycle.
// A last vertex adds the closing edge and the two centroid divides, restoring
// at one bit a cycle (both divides skipped when the area is zero).
// in_stall stays high from an accepted beat until that vertex is done; the result
// sits in an output register, so a new polygon may start while it waits.
// rst is synchronous and clears the controller and the sums.
module polygon_area_centroid_energy #(
  parameter int unsigned MAX_VERTICES = pcae_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] site_x,
  input  logic signed [31:0] site_y,
  input  logic               last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [62:0]        area_out,
  output logic signed [31:0] centroid_x,
  output logic signed [31:0] centroid_y,
  output logic [62:0]        energy_out,
  output logic               degenerate,
  output logic               saturated
);

  pcae_pkg::cmd_t    cmd;
  pcae_pkg::status_t status;

  pcae_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (last_vertex),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  pcae_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .site_x     (site_x),
    .site_y     (site_y),
    .area_out   (area_out),
    .centroid_x (centroid_x),
    .centroid_y (centroid_y),
    .energy_out (energy_out),
    .degenerate (degenerate),
    .saturated  (saturated)
  );

endmodule

### rtl/pcae_check.sv
`include "polygon_area_centroid_energy_assert.svh"

module pcae_check (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [62:0]        area_out,
  input logic signed [31:0] centroid_x,
  input logic signed [31:0] centroid_y,
  input logic [62:0]        energy_out,
  input logic               degenerate,
  input logic               saturated
);

  // Hold a stalled result beat
  `PCAE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")

  // Degenerate flag follows a zero area
  `PCAE_ASSERT_NOW(a_degen_area, out_valid, degenerate == (area_out == 63'd0), "degenerate flag does not match area")

  // Zero centroid on a degenerate polygon
  `PCAE_ASSERT_NOW(a_degen_cent, out_valid && degenerate, (centroid_x == 32'sd0) && (centroid_y == 32'sd0), "nonzero centroid on degenerate polygon")

  // Saturation flag follows a clipped sum
  `PCAE_ASSERT_NOW(a_sat_flag, out_valid, saturated == ((area_out == {63{1'b1}}) || (energy_out == {63{1'b1}})), "saturated flag does not match sums")

endmodule

bind polygon_area_centroid_energy pcae_check u_check (.*);

### dv/polygon_area_centroid_energy_tb.sv
module polygon_area_centroid_energy_tb;

  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned VERTEX_CAP = pcae_pkg::MAX_VERTICES_DEF;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned RANDOM_VERTICES = 400;

  typedef struct {
    logic [62:0]        area;
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic [62:0]        energy;
    logic               degen;
    logic               sat;
  } polygon_result_t;

  // Polygon predictor and the queue of expected polygon results
  class polygon_scoreboard;
    longint first_x, first_y, prev_x, prev_y, site_px, site_py;
    int unsigned count;
    logic [63:0] area_acc, energy_acc, shoelace_x, shoelace_y;
    polygon_result_t expected_polys[$];
    int unsigned mismatches;

    function void clear();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0; site_px = 0; site_py = 0;
      count = 0; area_acc = 0; energy_acc = 0; shoelace_x = 0; shoelace_y = 0;
    endfunction

    function logic [63:0] sat_add(logic [63:0] s, logic [63:0] t);
      return (t > SUM_MAX - s) ? SUM_MAX : s + t;
    endfunction

    // Shoelace contribution of edge u -> v
    function void add_edge(longint ux, longint uy, longint vx, longint vy);
      longint cr;
      logic signed [127:0] a, b, t;
      cr = ux * vy - uy * vx;
      b = cr;
      a = ux + vx;
      t = (a * b) >>> 48;
      shoelace_x += t[63:0];
      a = uy + vy;
      t = (a * b) >>> 48;
      shoelace_y += t[63:0];
    endfunction

    // Fan triangle (first, prev, new) area and second moment about the site
    function void add_triangle(longint x, longint y);
      logic signed [127:0] ax, ay, bx, by, p_x, p_y, q_x, q_y, r_x, r_y, cr, e;
      logic [127:0] u, m, q;
      logic [63:0] el, c4, t;
      ax = prev_x - first_x; ay = prev_y - first_y;
      bx = x - first_x;      by = y - first_y;
      p_x = first_x - site_px; p_y = first_y - site_py;
      q_x = prev_x - site_px;  q_y = prev_y - site_py;
      r_x = x - site_px;       r_y = y - site_py;
      cr = ax * by - ay * bx;
      if (cr < 0) cr = -cr;
      u = cr >> 5;
      area_acc = sat_add(area_acc, u[63:0]);
      e = p_x * p_x + p_y * p_y + p_x * q_x + p_y * q_y + p_x * r_x + p_y * r_y
        + q_x * q_x + q_y * q_y + q_x * r_x + q_y * r_y + r_x * r_x + r_y * r_y;
      u = e >> 4;
      el = u[63:0];
      u = cr >> 4;
      c4 = u[63:0];
      m = {64'b0, el} * {64'b0, c4};
      q = (m >> 56) / 128'd12;
      t = (q > {64'b0, SUM_MAX}) ? SUM_MAX : q[63:0];
      energy_acc = sat_add(energy_acc, t);
    endfunction

    function logic signed [31:0] centroid_of(logic [63:0] s);
      logic [127:0] v, den, q;
      logic neg;
      neg = s[63];
      v = {{64{s[63]}}, s};
      if (neg) v = -v;
      den = {64'b0, area_acc} * 128'd6;
      q = (v << 44) / den;
      if (!neg) return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (q > 128'h8000_0000) return 32'h8000_0000;
      return -q[31:0];
    endfunction

    // Note one accepted vertex beat
    function void note_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                              logic signed [31:0] sx, logic signed [31:0] sy, logic last);
      longint x, y;
      polygon_result_t r;
      x = vx; y = vy;
      if (count < VERTEX_CAP) begin
        if (count == 0) begin
          site_px = sx; site_py = sy; first_x = x; first_y = y;
        end else begin
          add_edge(prev_x, prev_y, x, y);
          if (count >= 2) add_triangle(x, y);
        end
        prev_x = x; prev_y = y;
        count++;
      end
      if (!last) return;
      add_edge(prev_x, prev_y, first_x, first_y);
      r.degen = (area_acc == 0);
      r.area = area_acc[62:0];
      r.energy = energy_acc[62:0];
      r.cen_x = r.degen ? 32'sd0 : centroid_of(shoelace_x);
      r.cen_y = r.degen ? 32'sd0 : centroid_of(shoelace_y);
      r.sat = (area_acc == SUM_MAX) || (energy_acc == SUM_MAX);
      expected_polys = {expected_polys, r};
      clear();
    endfunction

    // Check one result beat against the oldest expectation
    function void check_result(polygon_result_t got);
      polygon_result_t exp_r;
      if (expected_polys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: area %h", got.area);
        return;
      end
      exp_r = expected_polys.pop_front();
      if (got.area !== exp_r.area || got.cen_x !== exp_r.cen_x ||
          got.cen_y !== exp_r.cen_y || got.energy !== exp_r.energy ||
          got.degen !== exp_r.degen || got.sat !== exp_r.sat) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: area %h cx %h cy %h energy %h degen %b sat %b",
                   exp_r.area, exp_r.cen_x, exp_r.cen_y, exp_r.energy, exp_r.degen, exp_r.sat);
          $display("         got: area %h cx %h cy %h energy %h degen %b sat %b",
                   got.area, got.cen_x, got.cen_y, got.energy, got.degen, got.sat);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] vertex_x = '0, vertex_y = '0, site_x = '0, site_y = '0;
  logic last_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [62:0] area_out, energy_out;
  logic signed [31:0] centroid_x, centroid_y;
  logic degenerate, saturated;

  polygon_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;

  polygon_area_centroid_energy i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .site_x(site_x), .site_y(site_y),
    .last_vertex(last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .area_out(area_out), .centroid_x(centroid_x), .centroid_y(centroid_y),
    .energy_out(energy_out), .degenerate(degenerate), .saturated(saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one vertex beat; valid stays high afterwards until the next call decides
  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] sx, logic signed [31:0] sy, logic last);
    int unsigned gap;
    gap = (sent < 2000 && $urandom_range(0, 3) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    vertex_x = x; vertex_y = y; site_x = sx; site_y = sy; last_vertex = last;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_vertex(x, y, sx, sy, last);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int unsigned scale);
    case (scale)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0000_FFFF)) - 32'sd32768;
      2: return $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
      default: return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000)
                      ^ $signed($urandom_range(0, 255));
    endcase
  endfunction

  // Random polygon with one vertex scale; its site rides on the first beat
  task automatic send_polygon(int unsigned n);
    int unsigned scale;
    logic signed [31:0] sx, sy;
    scale = $urandom_range(0, 3);
    sx = rand_coord($urandom_range(0, 3));
    sy = rand_coord($urandom_range(0, 3));
    for (int unsigned i = 0; i < n; i++)
      send_vertex(rand_coord(scale), rand_coord(scale),
                  (i == 0) ? sx : $urandom, (i == 0) ? sy : $urandom, i == n - 1);
  endtask

  // Randomly stall the result channel
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      free_left = $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(50, 400);
      out_stall <= (stall_left > 0);
    end
  end

  // Check results and guard the run length
  always @(posedge clk) begin
    polygon_result_t got;
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      got.area = area_out; got.cen_x = centroid_x; got.cen_y = centroid_y;
      got.energy = energy_out; got.degen = degenerate; got.sat = saturated;
      sb.check_result(got);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE = 32'sh4000_0000;

  initial begin
    int unsigned wait_cycles;
    sb = new();
    sb.clear();
    sb.mismatches = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Lone last vertex, then a two-vertex run
    send_vertex(ONE, ONE, 32'sd0, 32'sd0, 1'b1);
    send_vertex(ONE, 32'sd0, ONE, ONE, 1'b0);
    send_vertex(32'sd0, ONE, 32'sd0, 32'sd0, 1'b1);
    // Unit square counterclockwise, then a clockwise right triangle
    send_vertex(32'sd0, 32'sd0, 32'sh2000_0000, 32'sh2000_0000, 1'b0);
    send_vertex(ONE, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_vertex(ONE, ONE, 32'sd0, 32'sd0, 1'b0);
    send_vertex(32'sd0, ONE, 32'sd0, 32'sd0, 1'b1);
    send_vertex(32'sd0, 32'sd0, PMIN, PMAX, 1'b0);
    send_vertex(32'sd0, ONE, 32'sd0, 32'sd0, 1'b0);
    send_vertex(ONE, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    // Collinear points give zero area
    send_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_vertex(ONE, ONE, 32'sd0, 32'sd0, 1'b0);
    send_vertex(PMIN, PMIN, 32'sd0, 32'sd0, 1'b1);
    // Extreme corners with a far site, enough to clip the energy
    send_vertex(PMIN, PMIN, PMAX, PMAX, 1'b0);
    send_vertex(PMAX, PMIN, 32'sd0, 32'sd0, 1'b0);
    send_vertex(PMAX, PMAX, 32'sd0, 32'sd0, 1'b0);
    send_vertex(PMIN, PMAX, 32'sd0, 32'sd0, 1'b0);
    send_vertex(PMIN, PMIN, 32'sd0, 32'sd0, 1'b0);
    send_vertex(PMAX, PMIN, 32'sd0, 32'sd0, 1'b0);
    send_vertex(PMAX, PMAX, 32'sd0, 32'sd0, 1'b1);

    // Random polygons, mostly well formed, some too short
    while (sent < RANDOM_VERTICES) begin
      if ($urandom_range(0, 9) == 0) send_polygon($urandom_range(1, 2));
      else send_polygon($urandom_range(3, 9));
    end
    in_valid = 1'b0;

    // Drain
    wait_cycles = 0;
    while (sb.expected_polys.size() > 0 && wait_cycles < 200_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (500) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_polys.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
